### sv/triangle_normal_and_bounds_unit_macros.svh
// ----------------------------------------------------------------------------
// Triangle normal and bounds unit: assertion macros
// Concurrent checks clocked on i_clk, with or without the reset gate.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NORMAL_AND_BOUNDS_UNIT_MACROS_SVH
`define TRIANGLE_NORMAL_AND_BOUNDS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TNB_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tnb check failed");
`define TNB_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("tnb check failed");
`else
`define TNB_ASSERT(label, prop)
`define TNB_ASSERT_ALWAYS(label, prop)
`endif
`endif

### sv/tnb_pkg.sv
// ----------------------------------------------------------------------------
// Triangle normal and bounds package
// Widths, queue item, result word and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tnb_pkg;

    localparam int CoordW   = 16;
    localparam int DiffW    = CoordW + 1;
    localparam int ProdW    = 2 * DiffW;
    localparam int CrossW   = ProdW + 1;
    localparam int MagW     = CrossW - 1;
    localparam int NormW    = 30;
    localparam int SqW      = 62;
    localparam int RootW    = 31;
    localparam int FracBits = 14;
    localparam int QW       = FracBits + 1;
    localparam int NumW     = NormW + FracBits + 1;
    localparam int OutW     = 16;
    localparam int InDataW  = 9 * CoordW;
    localparam int OutDataW = 8 * OutW;
    localparam int FifoDepth = 2;

    typedef logic signed [DiffW-1:0]  t_diff;
    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_diff  ux, uy, uz, vx, vy, vz;
        t_coord xmin, xmax, ymin, ymax, zmin;
    } t_item;

    typedef struct packed {
        logic signed [OutW-1:0] nx, ny, nz;
        logic                   degen;
        t_coord                 xmin, xmax, ymin, ymax, zmin;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CROSS, ST_ABS, ST_NORM, ST_SQR, ST_ROOT, ST_PREP, ST_DIV, ST_DONE
    } t_state;

endpackage

`default_nettype wire

### sv/tnb_front.sv
// ----------------------------------------------------------------------------
// Triangle normal and bounds front end
// Accepts triangles, updates running bounds, forms edge vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module tnb_front import tnb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_first,
    input  wire logic [InDataW-1:0] i_data,
    input  wire t_fifo_stat         i_stat,
    output logic                    o_ready,
    output logic                    o_push,
    output t_item                   o_item
);

    t_coord w_v [9];
    t_coord r_xmin, r_xmax, r_ymin, r_ymax, r_zmin;
    t_coord n_xmin, n_xmax, n_ymin, n_ymax, n_zmin;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_v[k] = t_coord'(i_data[k*CoordW +: CoordW]);
        end
    end

    always_comb begin
        n_xmin = i_first ? w_v[0] : r_xmin;
        n_xmax = i_first ? w_v[0] : r_xmax;
        n_ymin = i_first ? w_v[1] : r_ymin;
        n_ymax = i_first ? w_v[1] : r_ymax;
        n_zmin = i_first ? w_v[2] : r_zmin;
        for (int k = 0; k < 3; k++) begin
            if (w_v[3*k]   < n_xmin) n_xmin = w_v[3*k];
            if (w_v[3*k]   > n_xmax) n_xmax = w_v[3*k];
            if (w_v[3*k+1] < n_ymin) n_ymin = w_v[3*k+1];
            if (w_v[3*k+1] > n_ymax) n_ymax = w_v[3*k+1];
            if (w_v[3*k+2] < n_zmin) n_zmin = w_v[3*k+2];
        end
    end

    assign o_ready = !i_stat.full;
    assign o_push  = i_valid && !i_stat.full;

    always_comb begin
        o_item.ux   = t_diff'(w_v[3]) - t_diff'(w_v[0]);
        o_item.uy   = t_diff'(w_v[4]) - t_diff'(w_v[1]);
        o_item.uz   = t_diff'(w_v[5]) - t_diff'(w_v[2]);
        o_item.vx   = t_diff'(w_v[6]) - t_diff'(w_v[0]);
        o_item.vy   = t_diff'(w_v[7]) - t_diff'(w_v[1]);
        o_item.vz   = t_diff'(w_v[8]) - t_diff'(w_v[2]);
        o_item.xmin = n_xmin;
        o_item.xmax = n_xmax;
        o_item.ymin = n_ymin;
        o_item.ymax = n_ymax;
        o_item.zmin = n_zmin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin <= '0;
            r_xmax <= '0;
            r_ymin <= '0;
            r_ymax <= '0;
            r_zmin <= '0;
        end else if (o_push) begin
            r_xmin <= n_xmin;
            r_xmax <= n_xmax;
            r_ymin <= n_ymin;
            r_ymax <= n_ymax;
            r_zmin <= n_zmin;
        end
    end

endmodule

`default_nettype wire

### sv/tnb_fifo.sv
// ----------------------------------------------------------------------------
// Triangle normal and bounds queue
// Two-entry queue between front end and normal sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tnb_fifo import tnb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output t_fifo_stat o_stat
);

    localparam int PtrW = $clog2(FifoDepth);

    t_item           r_mem [FifoDepth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [PtrW:0]   r_cnt;

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (PtrW+1)'(FifoDepth));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(i_push) - (PtrW+1)'(i_pop);
        end
    end

endmodule

`default_nettype wire

### sv/tnb_back.sv
// ----------------------------------------------------------------------------
// Triangle normal and bounds back end
// Sequencer for cross product, normalization, square root and divides.
// ----------------------------------------------------------------------------
`default_nettype none

module tnb_back import tnb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire logic  i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_result
);

    t_state                    r_state, n_state;
    logic [4:0]                r_step;
    t_item                     r_item;
    logic signed [CrossW-1:0]  r_c [3];
    logic [MagW-1:0]           r_a [3];
    logic                      r_neg [3];
    logic                      r_degen;
    logic [SqW-1:0]            r_s, r_res, r_bit;
    logic [RootW-1:0]          r_rem [3];
    logic [FracBits:0]         r_num [3];
    logic [QW-1:0]             r_q [3];

    t_diff                     w_opa, w_opb;
    logic signed [ProdW-1:0]   w_prod;
    logic [MagW-1:0]           w_mx;
    logic [2*NormW-1:0]        w_sq;
    logic [SqW-1:0]            w_trial;
    logic                      w_all_zero;
    logic [NumW-1:0]           w_numer [3];
    logic [RootW:0]            w_cand [3];
    logic signed [CrossW-1:0]  w_abs [3];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (!i_empty) n_state = ST_CROSS;
            ST_CROSS: if (r_step == 5'd5) n_state = ST_ABS;
            ST_ABS:   n_state = w_all_zero ? ST_DONE : ST_NORM;
            ST_NORM:  if (w_mx[MagW-1:NormW] == '0 && w_mx[NormW-1]) n_state = ST_SQR;
            ST_SQR:   if (r_step == 5'd2) n_state = ST_ROOT;
            ST_ROOT:  if (r_step == 5'(RootW - 1)) n_state = ST_PREP;
            ST_PREP:  n_state = ST_DIV;
            ST_DIV:   if (r_step == 5'(QW - 1)) n_state = ST_DONE;
            ST_DONE:  if (i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop   = (r_state == ST_IDLE) && !i_empty;
        o_valid = (r_state == ST_DONE);
        o_result.degen = r_degen;
        o_result.xmin  = r_item.xmin;
        o_result.xmax  = r_item.xmax;
        o_result.ymin  = r_item.ymin;
        o_result.ymax  = r_item.ymax;
        o_result.zmin  = r_item.zmin;
        if (r_degen) begin
            o_result.nx = '0;
            o_result.ny = '0;
            o_result.nz = '0;
        end else begin
            o_result.nx = r_neg[0] ? -OutW'(r_q[0]) : OutW'(r_q[0]);
            o_result.ny = r_neg[1] ? -OutW'(r_q[1]) : OutW'(r_q[1]);
            o_result.nz = r_neg[2] ? -OutW'(r_q[2]) : OutW'(r_q[2]);
        end
    end

    // shared datapath pieces
    always_comb begin
        unique case (r_step[2:0])
            3'd0:    begin w_opa = r_item.vy; w_opb = r_item.uz; end
            3'd1:    begin w_opa = r_item.vz; w_opb = r_item.uy; end
            3'd2:    begin w_opa = r_item.vz; w_opb = r_item.ux; end
            3'd3:    begin w_opa = r_item.vx; w_opb = r_item.uz; end
            3'd4:    begin w_opa = r_item.vx; w_opb = r_item.uy; end
            3'd5:    begin w_opa = r_item.vy; w_opb = r_item.ux; end
            default: begin w_opa = r_item.vy; w_opb = r_item.uz; end
        endcase
        w_prod = w_opa * w_opb;
        w_mx = r_a[0];
        if (r_a[1] > w_mx) w_mx = r_a[1];
        if (r_a[2] > w_mx) w_mx = r_a[2];
        w_sq    = r_a[r_step[1:0]][NormW-1:0] * r_a[r_step[1:0]][NormW-1:0];
        w_trial = r_res + r_bit;
        w_all_zero = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        for (int i = 0; i < 3; i++) begin
            w_abs[i]   = r_c[i][CrossW-1] ? -r_c[i] : r_c[i];
            w_numer[i] = {1'b0, r_a[i][NormW-1:0], FracBits'(0)}
                       + NumW'(r_res[RootW-1:1]);
            w_cand[i]  = {r_rem[i], r_num[i][FracBits]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? 5'd0 : r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_item <= i_item;
                for (int i = 0; i < 3; i++) r_c[i] <= '0;
            end
            ST_CROSS: begin
                if (r_step[0])
                    r_c[r_step[2:1]] <= r_c[r_step[2:1]] - CrossW'(w_prod);
                else
                    r_c[r_step[2:1]] <= r_c[r_step[2:1]] + CrossW'(w_prod);
            end
            ST_ABS: begin
                r_degen <= w_all_zero;
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_c[i][CrossW-1];
                    r_a[i]   <= w_abs[i][MagW-1:0];
                end
                r_s   <= '0;
                r_res <= '0;
                r_bit <= SqW'(1) << (SqW - 2);
            end
            ST_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (w_mx[MagW-1:NormW] != '0)
                        r_a[i] <= r_a[i] >> 1;
                    else if (!w_mx[NormW-1])
                        r_a[i] <= r_a[i] << 1;
                end
            end
            ST_SQR: begin
                r_s <= r_s + SqW'(w_sq);
            end
            ST_ROOT: begin
                if (r_s >= w_trial) begin
                    r_s   <= r_s - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_PREP: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= RootW'(w_numer[i][NumW-1:FracBits+1]);
                    r_num[i] <= w_numer[i][FracBits:0];
                end
            end
            ST_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (w_cand[i] >= {1'b0, r_res[RootW-1:0]}) begin
                        r_rem[i] <= RootW'(w_cand[i] - {1'b0, r_res[RootW-1:0]});
                        r_q[i]   <= {r_q[i][QW-2:0], 1'b1};
                    end else begin
                        r_rem[i] <= w_cand[i][RootW-1:0];
                        r_q[i]   <= {r_q[i][QW-2:0], 1'b0};
                    end
                    r_num[i] <= r_num[i] << 1;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/triangle_normal_and_bounds_unit.sv
// ----------------------------------------------------------------------------
// Triangle normal and bounds unit
// Unit face normal (V x U) in Q2.14 plus running bounding box per triangle.
//
// Input channel s_axis: one word per triangle, nine Q8.8 coordinates in
// tdata, tuser set on the first triangle of a mesh (seeds the bounds).
// Output channel m_axis: one word per triangle, normal and bounds in tdata,
// tuser set when the triangle is degenerate (normal given as zero).
// The front end updates the bounds and edge vectors as a word is taken and
// parks it in a two-entry queue; the back end sequencer runs one triangle
// at a time: cross product from six products on one multiplier, one-bit
// normalizing shifts, 3 squares, 31 square root steps, 1 setup and 15
// divide steps (three dividers side by side); degenerate triangles skip
// the normalization, root and divide steps.
// The result is held on m_axis until taken; a stalled receiver holds the
// sequencer, and input words are still taken until the queue fills.
// Reset clears the bounds to zero, empties the queue and idles the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_normal_and_bounds_unit_macros.svh"

module triangle_normal_and_bounds_unit import tnb_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    // first_triangle
    input  wire logic                s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // normal_x, normal_y, normal_z, bound_x_min, bound_x_max, bound_y_min,
    // bound_y_max, bound_z_min
    output logic [OutDataW-1:0]      m_axis_tdata,
    // degenerate
    output logic                     m_axis_tuser
);

    logic       w_push, w_pop;
    t_item      w_push_item, w_head_item;
    t_fifo_stat w_stat;
    t_result    w_result;

    tnb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_first (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .i_stat  (w_stat),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    tnb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_stat)
    );

    tnb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_head_item),
        .i_empty  (w_stat.empty),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {w_result.zmin, w_result.ymax, w_result.ymin, w_result.xmax,
                           w_result.xmin, w_result.nz, w_result.ny, w_result.nx};
    assign m_axis_tuser = w_result.degen;

    `TNB_ASSERT(a_degen_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:0] == '0)
    `TNB_ASSERT(a_normal_nonzero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[47:0] != '0)
    `TNB_ASSERT(a_queue_sane, !(w_stat.full && w_stat.empty))
    `TNB_ASSERT(a_pop_nonempty, w_pop |-> !w_stat.empty)
    `TNB_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !m_axis_tvalid)

endmodule

`default_nettype wire
